// ===== src/act_pkg.sv =====
// act_pkg: shared types, constants and helper functions for the altitude climb tracker.
// Used by every RTL module of the block and by its checker.
`timescale 1ns / 1ps
`default_nettype none
package act_pkg;

	// Counter width for tops, bottoms and rejects
	localparam int COUNT_WIDTH = 16;
	localparam int COUNT_OUT_W = 16;
	localparam int COUNT_EXT_W = (COUNT_WIDTH > COUNT_OUT_W) ? COUNT_WIDTH : COUNT_OUT_W;

	// Field widths
	localparam int ALT_W     = 21;
	localparam int DIFF_W    = ALT_W + 1;
	localparam int PRES_W    = 17;
	localparam int DEAD_W    = 17;
	localparam int BAND_W    = 20;
	localparam int ASC_W     = 31;
	localparam int DESC_W    = 32;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_IDX_W  = 2;

	// Register reset values
	localparam logic [DEAD_W-1:0] DEAD_BAND_RST  = DEAD_W'(160);
	localparam logic [BAND_W-1:0] CLIMB_BAND_RST = BAND_W'(6800);
	localparam logic [PRES_W-1:0] PRES_LOW_RST   = PRES_W'(92000);
	localparam logic [PRES_W-1:0] PRES_HIGH_RST  = PRES_W'(107000);

	// Saturation limits of the totals
	localparam logic [ASC_W-1:0]         ASC_MAX  = '1;
	localparam logic signed [DESC_W-1:0] DESC_MIN = -32'sd2147483647;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEAD_BAND  = 2'd0,
		REG_CLIMB_BAND = 2'd1,
		REG_PRES_LOW   = 2'd2,
		REG_PRES_HIGH  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FAIL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		DIR_START = 2'd0,
		DIR_UP    = 2'd1,
		DIR_DOWN  = 2'd2
	} dir_t;

	typedef struct packed {
		logic [DEAD_W-1:0] dead_band_cm;
		logic [BAND_W-1:0] climb_band_cm;
		logic [PRES_W-1:0] pressure_low_pa;
		logic [PRES_W-1:0] pressure_high_pa;
	} cfg_t;

	typedef struct packed {
		logic                    cmd;
		logic [PRES_W-1:0]       pressure_pa;
		logic signed [ALT_W-1:0] altitude_cm;
		logic                    sensor_fail;
	} sample_t;

	typedef struct packed {
		status_t                  status;
		logic [ASC_W-1:0]         climbed_total_cm;
		logic signed [DESC_W-1:0] descent_total_cm;
		logic [COUNT_OUT_W-1:0]   top_count;
		logic [COUNT_OUT_W-1:0]   bottom_count;
		dir_t                     direction;
		logic [COUNT_OUT_W-1:0]   failure_count;
	} result_t;

	// Saturating increment
	function automatic logic [COUNT_WIDTH-1:0] cnt_bump(input logic [COUNT_WIDTH-1:0] c);
		return (c == {COUNT_WIDTH{1'b1}}) ? c : c + 1'b1;
	endfunction

	// Low output bits of a counter, zero-extended when the counter is narrower
	function automatic logic [COUNT_OUT_W-1:0] cnt_out(input logic [COUNT_WIDTH-1:0] c);
		logic [COUNT_EXT_W-1:0] ext;
		ext = COUNT_EXT_W'(c);
		return ext[COUNT_OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== src/act_cfg.sv =====
// act_cfg: configuration register file (bands and pressure window).
// Depends on act_pkg.
`timescale 1ns / 1ps
`default_nettype none
module act_cfg (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [act_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [act_pkg::CFG_DATA_W-1:0]   cfg_data,
	output act_pkg::cfg_t                         cfg
);

	act_pkg::cfg_t cfg_q;
	act_pkg::cfg_idx_t idx;

	assign idx = act_pkg::cfg_idx_t'(cfg_index);

	// Register writes, truncated to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dead_band_cm     <= act_pkg::DEAD_BAND_RST;
			cfg_q.climb_band_cm    <= act_pkg::CLIMB_BAND_RST;
			cfg_q.pressure_low_pa  <= act_pkg::PRES_LOW_RST;
			cfg_q.pressure_high_pa <= act_pkg::PRES_HIGH_RST;
		end else if (cfg_we) begin
			unique case (idx)
				act_pkg::REG_DEAD_BAND:  cfg_q.dead_band_cm <= cfg_data[act_pkg::DEAD_W-1:0];
				act_pkg::REG_CLIMB_BAND: cfg_q.climb_band_cm <= cfg_data[act_pkg::BAND_W-1:0];
				act_pkg::REG_PRES_LOW:   cfg_q.pressure_low_pa <= cfg_data[act_pkg::PRES_W-1:0];
				act_pkg::REG_PRES_HIGH:  cfg_q.pressure_high_pa <= cfg_data[act_pkg::PRES_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== src/act_core.sv =====
// act_core: tracker state registers and the single-pass update for one sample.
// Depends on act_pkg; driven by the top level's input stage.
`timescale 1ns / 1ps
`default_nettype none
module act_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  act_pkg::sample_t sample,
	input  act_pkg::cfg_t    cfg,
	output act_pkg::result_t result
);

	localparam int DW = act_pkg::DIFF_W;
	localparam int CW = act_pkg::COUNT_WIDTH;

	logic signed [act_pkg::ALT_W-1:0]  cur_alt_q, band_base_q, turn_base_q;
	logic [act_pkg::ASC_W-1:0]         ascent_q;
	logic signed [act_pkg::DESC_W-1:0] descent_q;
	act_pkg::dir_t                     dir_q;
	logic [CW-1:0]                     tops_q, bottoms_q, rejects_q;

	logic signed [act_pkg::ALT_W-1:0]  cur_alt_d, band_base_d, turn_base_d;
	logic [act_pkg::ASC_W-1:0]         ascent_d;
	logic signed [act_pkg::DESC_W-1:0] descent_d;
	act_pkg::dir_t                     dir_d;
	logic [CW-1:0]                     tops_d, bottoms_d, rejects_d;
	act_pkg::status_t                  status_d;

	logic signed [DW-1:0]              d_band, d_turn, dead_s, band_s;
	logic [act_pkg::ASC_W:0]           asc_sum;
	logic signed [act_pkg::DESC_W:0]   desc_sum;
	logic signed [act_pkg::ALT_W-1:0]  alt;

	assign alt    = sample.altitude_cm;
	assign d_band = {alt[act_pkg::ALT_W-1], alt} - {band_base_q[act_pkg::ALT_W-1], band_base_q};
	assign d_turn = {alt[act_pkg::ALT_W-1], alt} - {turn_base_q[act_pkg::ALT_W-1], turn_base_q};
	assign dead_s = signed'(DW'(cfg.dead_band_cm));
	assign band_s = signed'(DW'(cfg.climb_band_cm));

	// Total adders, one bit wider for the saturation check
	assign asc_sum  = {1'b0, ascent_q} + (act_pkg::ASC_W + 1)'(d_band);
	assign desc_sum = {descent_q[act_pkg::DESC_W-1], descent_q}
		+ {{(act_pkg::DESC_W + 1 - DW){d_band[DW-1]}}, d_band};

	// Next state for one sample
	always_comb begin
		cur_alt_d   = cur_alt_q;
		band_base_d = band_base_q;
		turn_base_d = turn_base_q;
		ascent_d    = ascent_q;
		descent_d   = descent_q;
		dir_d       = dir_q;
		tops_d      = tops_q;
		bottoms_d   = bottoms_q;
		rejects_d   = rejects_q;

		if (sample.sensor_fail) begin
			status_d  = act_pkg::STATUS_FAIL;
			rejects_d = act_pkg::cnt_bump(rejects_q);
		end else if (sample.pressure_pa < cfg.pressure_low_pa
				|| sample.pressure_pa > cfg.pressure_high_pa) begin
			status_d  = act_pkg::STATUS_RANGE;
			rejects_d = act_pkg::cnt_bump(rejects_q);
		end else begin
			status_d  = act_pkg::STATUS_OK;
			cur_alt_d = alt;
			// dead band: totals
			if (d_band > dead_s) begin
				ascent_d    = asc_sum[act_pkg::ASC_W] ? act_pkg::ASC_MAX
					: asc_sum[act_pkg::ASC_W-1:0];
				band_base_d = alt;
			end else if (d_band < -dead_s) begin
				descent_d   = (desc_sum < $signed({act_pkg::DESC_MIN[act_pkg::DESC_W-1],
					act_pkg::DESC_MIN})) ? act_pkg::DESC_MIN
					: desc_sum[act_pkg::DESC_W-1:0];
				band_base_d = alt;
			end
			// climb band: turn tracker
			if (d_turn > band_s) begin
				turn_base_d = alt;
				if (dir_q != act_pkg::DIR_UP) begin
					dir_d  = act_pkg::DIR_UP;
					tops_d = act_pkg::cnt_bump(tops_q);
				end
			end else if (d_turn < -band_s) begin
				turn_base_d = alt;
				if (dir_q != act_pkg::DIR_DOWN) begin
					dir_d     = act_pkg::DIR_DOWN;
					bottoms_d = act_pkg::cnt_bump(bottoms_q);
				end
			end
		end

		// init: clear after the step, rebase on last accepted altitude
		if (sample.cmd) begin
			ascent_d    = '0;
			descent_d   = '0;
			band_base_d = cur_alt_d;
			turn_base_d = cur_alt_d;
			tops_d      = '0;
			bottoms_d   = '0;
			dir_d       = act_pkg::DIR_START;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_alt_q   <= '0;
			band_base_q <= '0;
			turn_base_q <= '0;
			ascent_q    <= '0;
			descent_q   <= '0;
			dir_q       <= act_pkg::DIR_START;
			tops_q      <= '0;
			bottoms_q   <= '0;
			rejects_q   <= '0;
		end else if (step) begin
			cur_alt_q   <= cur_alt_d;
			band_base_q <= band_base_d;
			turn_base_q <= turn_base_d;
			ascent_q    <= ascent_d;
			descent_q   <= descent_d;
			dir_q       <= dir_d;
			tops_q      <= tops_d;
			bottoms_q   <= bottoms_d;
			rejects_q   <= rejects_d;
		end
	end

	// Result beat reflects the state after this sample
	always_comb begin
		result.status           = status_d;
		result.climbed_total_cm = ascent_d;
		result.descent_total_cm = descent_d;
		result.top_count        = act_pkg::cnt_out(tops_d);
		result.bottom_count     = act_pkg::cnt_out(bottoms_d);
		result.direction        = dir_d;
		result.failure_count    = act_pkg::cnt_out(rejects_d);
	end

endmodule
`default_nettype wire

// ===== src/altitude_climb_tracker_top.sv =====
// Altitude climb tracker top: input register, update core and output register.
// An input beat passes the input register, then the result register, on its way to its result beat.
// One sample per cycle unless out_ready stalls the result; the core's update is combinational.
// Reset (arst_n low, asynchronous): bands and window take their defaults, valid flags and tracker state clear.
// Depends on act_pkg, act_cfg and act_core.
`timescale 1ns / 1ps
`default_nettype none
module altitude_climb_tracker_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [act_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [act_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic                            cmd,
	input  wire logic [act_pkg::PRES_W-1:0]      pressure_pa,
	input  wire logic signed [act_pkg::ALT_W-1:0] altitude_cm,
	input  wire logic                            sensor_fail,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [1:0]                           status,
	output logic [act_pkg::ASC_W-1:0]            climbed_total_cm,
	output logic signed [act_pkg::DESC_W-1:0]    descent_total_cm,
	output logic [act_pkg::COUNT_OUT_W-1:0]      top_count,
	output logic [act_pkg::COUNT_OUT_W-1:0]      bottom_count,
	output logic [1:0]                           direction,
	output logic [act_pkg::COUNT_OUT_W-1:0]      failure_count
);

	act_pkg::cfg_t    cfg;
	act_pkg::sample_t sample_s1;
	act_pkg::result_t res_d, res_q;
	logic             valid_s1, out_valid_q, advance, step;

	act_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Pipeline moves when the result register is free or being drained
	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1.cmd         <= cmd;
			sample_s1.pressure_pa <= pressure_pa;
			sample_s1.altitude_cm <= altitude_cm;
			sample_s1.sensor_fail <= sensor_fail;
		end
	end

	act_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (res_d)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_d;
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = res_q.status;
	assign climbed_total_cm = res_q.climbed_total_cm;
	assign descent_total_cm = res_q.descent_total_cm;
	assign top_count        = res_q.top_count;
	assign bottom_count     = res_q.bottom_count;
	assign direction        = res_q.direction;
	assign failure_count    = res_q.failure_count;

endmodule
`default_nettype wire

// ===== src/act_checker.sv =====
// act_checker: port-level assertions for the altitude climb tracker, bound to the top level.
// Depends on act_pkg.
`timescale 1ns / 1ps
`default_nettype none
module act_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             out_valid,
	input wire logic                             out_ready,
	input wire logic [act_pkg::ASC_W-1:0]        climbed_total_cm,
	input wire logic signed [act_pkg::DESC_W-1:0] descent_total_cm,
	input wire logic [act_pkg::COUNT_OUT_W-1:0]  failure_count
);

	// A stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	// A stalled result beat keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(climbed_total_cm) && $stable(descent_total_cm)
			&& $stable(failure_count))
		else $error("result payload changed while stalled");

	// Descent total is never positive
	a_desc_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> descent_total_cm[act_pkg::DESC_W-1] || descent_total_cm == '0)
		else $error("descent total positive");

	// No result right out of reset
	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !out_valid)
		else $error("result beat right after reset");

endmodule

bind altitude_climb_tracker_top act_checker u_act_checker (.*);
`default_nettype wire
